>>> design/arw_pkg.sv
// Package for the anti-replay window check: sizes, FSM state type and
// the command/status structs between controller and datapath.
// No dependencies.
package arw_pkg;

    // Window size; a power of two of at least 128 (two or more bitmap rows).
    localparam int WINDOW = 1024;
    localparam int SEQ_W  = 64;
    localparam int WORD_W = 64;
    localparam int ROWS   = WINDOW / WORD_W;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROW_W  = IDX_W - BIT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SWEEP0,
        ST_SWEEP,
        ST_SWEEPEND,
        ST_FAR,
        ST_LOWRD,
        ST_LOWCHK,
        ST_DONE
    } arw_state_t;

    typedef struct packed {
        logic load;       // capture request and compare against highest
        logic rd_en;      // read a bitmap row
        logic rd_sweep;   // read address from sweep pointer, else seq row
        logic ptr_clr;    // restart sweep pointer
        logic ptr_step;   // advance sweep pointer
        logic wr_en;      // write a bitmap row
        logic wr_sweep;   // write row behind pointer with skipped bits cleared
        logic wr_far;     // drop all rows, write only the marked row
        logic take_high;  // highest <= seq
        logic reinit;     // highest <= 0
        logic push;       // load output register
        logic acc;        // result to push
    } arw_cmd_t;

    typedef struct packed {
        logic mode;
        logic bypass;
        logic eq;
        logic gt;
        logic far;
        logic bit_set;
        logic ptr_last;
        logic out_free;
    } arw_status_t;

endpackage

>>> design/arw_ctrl.sv
// Controller FSM for the anti-replay window check.
// Depends on arw_pkg; drives arw_datapath through arw_cmd_t.
module arw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  arw_pkg::arw_status_t status,
    output arw_pkg::arw_cmd_t    cmd
);
    import arw_pkg::*;

    arw_state_t state_reg, state_next;
    logic       acc_reg, acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.mode) begin
                    cmd.reinit = 1'b1;
                    acc_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (status.bypass) begin
                    acc_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (status.eq) begin
                    acc_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (status.gt && status.far) begin
                    state_next = ST_FAR;
                end else if (status.gt) begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_SWEEP0;
                end else if (status.far) begin
                    acc_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LOWRD;
                end
            end
            ST_SWEEP0: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sweep = 1'b1;
                cmd.ptr_step = 1'b1;
                state_next   = status.ptr_last ? ST_SWEEPEND : ST_SWEEP;
            end
            ST_SWEEP: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sweep = 1'b1;
                cmd.ptr_step = 1'b1;
                cmd.wr_en    = 1'b1;
                cmd.wr_sweep = 1'b1;
                if (status.ptr_last) begin
                    state_next = ST_SWEEPEND;
                end
            end
            ST_SWEEPEND: begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sweep  = 1'b1;
                cmd.take_high = 1'b1;
                acc_next      = 1'b1;
                state_next    = ST_DONE;
            end
            ST_FAR: begin
                cmd.wr_en     = 1'b1;
                cmd.wr_far    = 1'b1;
                cmd.take_high = 1'b1;
                acc_next      = 1'b1;
                state_next    = ST_DONE;
            end
            ST_LOWRD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOWCHK;
            end
            ST_LOWCHK: begin
                if (status.bit_set) begin
                    acc_next = 1'b0;
                end else begin
                    cmd.wr_en = 1'b1;
                    acc_next  = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.acc = acc_reg;
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/arw_datapath.sv
// Datapath for the anti-replay window check: highest number, compare,
// bitmap memory with row valid bits, sweep pointer and output register.
// Depends on arw_pkg; commanded by arw_ctrl.
module arw_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [63:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 cfg_wen,
    input  logic [0:0]           cfg_wdata,
    input  arw_pkg::arw_cmd_t    cmd,
    output arw_pkg::arw_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata
);
    import arw_pkg::*;

    logic [SEQ_W-1:0]  highest_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic              mode_reg;
    logic              bypass_reg;
    logic              eq_reg, gt_reg, far_reg;
    logic [IDX_W-1:0]  count_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [ROW_W-1:0]  ptr_reg;
    logic [ROWS-1:0]   row_valid_reg;
    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic              m_tvalid_reg;
    logic              m_acc_reg;

    logic [SEQ_W-1:0]  seq_in;
    logic              gt_in;
    logic [SEQ_W-1:0]  diff;
    logic [ROW_W-1:0]  seq_row;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  wr_row;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] clr_mask;
    logic [WORD_W-1:0] mark_mask;
    logic [WORD_W-1:0] wr_data;

    assign seq_in = s_tdata;
    assign gt_in  = seq_in > highest_reg;
    assign diff   = gt_in ? (seq_in - highest_reg) : (highest_reg - seq_in);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            seq_reg   <= seq_in;
            mode_reg  <= s_tuser[0];
            eq_reg    <= seq_in == highest_reg;
            gt_reg    <= gt_in;
            far_reg   <= diff[SEQ_W-1:IDX_W] != '0;
            count_reg <= diff[IDX_W-1:0] - IDX_W'(1);
            start_reg <= highest_reg[IDX_W-1:0] + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_reg <= '0;
        end else if (cmd.reinit) begin
            highest_reg <= '0;
        end else if (cmd.take_high) begin
            highest_reg <= seq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg <= 1'b0;
        end else if (cfg_wen) begin
            bypass_reg <= cfg_wdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_clr) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_step) begin
            ptr_reg <= ptr_reg + ROW_W'(1);
        end
    end

    assign seq_row = seq_reg[IDX_W-1:BIT_W];
    assign rd_row  = cmd.rd_sweep ? ptr_reg : seq_row;
    // the sweep writes back the row read in the cycle before
    assign wr_row  = cmd.wr_sweep ? (ptr_reg - ROW_W'(1)) : seq_row;
    assign word    = rd_valid_reg ? rd_data_reg : '0;

    always_comb begin
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] offs;
        for (int j = 0; j < WORD_W; j++) begin
            pos          = {wr_row, BIT_W'(j)};
            offs         = pos - start_reg;
            clr_mask[j]  = cmd.wr_sweep && (offs < count_reg);
            mark_mask[j] = pos == seq_reg[IDX_W-1:0];
        end
    end

    assign wr_data = (cmd.wr_far ? '0 : (word & ~clr_mask)) | mark_mask;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[rd_row];
            rd_valid_reg <= row_valid_reg[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.wr_en) begin
            if (cmd.wr_far) begin
                row_valid_reg <= {{(ROWS-1){1'b0}}, 1'b1} << wr_row;
            end else begin
                row_valid_reg[wr_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_acc_reg <= cmd.acc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_acc_reg};

    assign status.mode     = mode_reg;
    assign status.bypass   = bypass_reg;
    assign status.eq       = eq_reg;
    assign status.gt       = gt_reg;
    assign status.far      = far_reg;
    assign status.bit_set  = word[seq_reg[BIT_W-1:0]];
    assign status.ptr_last = ptr_reg == ROW_W'(ROWS - 1);
    assign status.out_free = !m_tvalid_reg || m_tready;

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_tvalid_reg || m_tready))
        else $error("result pushed over a waiting result");

    a_far_one_row: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.wr_en && cmd.wr_far) && $past(aresetn)) |-> $onehot(row_valid_reg))
        else $error("full clear left other rows valid");

    a_reinit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.reinit) && $past(aresetn)) |-> (highest_reg == '0))
        else $error("reinit did not clear highest");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !(cmd.wr_far && cmd.wr_sweep))
        else $error("two bitmap write sources at once");

endmodule

>>> design/anti_replay_window_check.sv
// Top level of the anti-replay window check.
// Depends on arw_pkg, arw_ctrl and arw_datapath.
//
// Usage:
//   s_ channel: one request per packet. s_tuser[0] is mode (0 check,
//   1 reinit highest to zero), s_tdata[63:0] is the sequence number.
//   m_ channel: one result per request, m_tdata[0] = accepted.
//   cfg_wen/cfg_wdata write the bypass bit; write only while idle.
// Timing: a request is taken in the idle state and worked on alone; the next
//   request can be taken in the cycle after the result is pushed. Paths:
//   Reinit, bypass, equal and too-old checks: decide state, then done state.
//   In-window older check: row read, test, mark.
//   Jump of a full window or more: all rows dropped at once.
//   Shorter forward jump: read-modify-write sweep over the 64-bit bitmap
//   rows, one row a cycle.
// Reset: highest number and bypass go to zero, every bitmap row valid bit
//   clears at once, so the block takes requests right after reset.
// Stall: the result waits in the output register; the next request is
//   still accepted and its result holds until the register is taken.
module anti_replay_window_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seq
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] accepted, [7:1] zero
    input  logic        cfg_wen,
    input  logic [0:0]  cfg_wdata  // [0] bypass
);
    import arw_pkg::*;

    arw_cmd_t    cmd;
    arw_status_t status;

    arw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    arw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
